// ----- src/lps_pkg.sv -----
// Shared types, widths and codes for the leaky PID controller.
// Used by the config register, controller, datapath and top-level files.
package lps_pkg;

	// Field widths.
	localparam int SIG_W   = 24;  // setpoint, measurement, leaky sum (Q16.8)
	localparam int ERR_W   = 25;  // error (Q17.8)
	localparam int DIFF_W  = 26;  // error difference (Q18.8)
	localparam int GAIN_W  = 24;  // gains (Q8.16)
	localparam int LIM_W   = 15;  // limits in whole units
	localparam int DRIVE_W = 16;  // result
	localparam int PROD_W  = DIFF_W + GAIN_W;
	localparam int ACC_W   = 52;  // product sums in Q.24
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 24;

	// Fraction bits.
	localparam int SIG_FRAC   = 8;
	localparam int DECAY_FRAC = 16;
	localparam int PROD_FRAC  = 24;

	// Decay factor 0.8 in Q0.16 and the rounding offset of its product.
	localparam logic signed [GAIN_W-1:0] DECAY_Q16 = 24'sd52429;
	localparam logic signed [ACC_W-1:0] DECAY_RND = 52'sd32768;
	// Bias that turns the floor shift of a negative sum into truncation toward zero.
	localparam logic signed [ACC_W-1:0] TRUNC_BIAS = 52'sd16777215;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INT_GAIN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_ACCUM_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_ITERM_LIMIT = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;
	localparam logic [IDX_W-1:0] REG_ERROR_SIGN  = 3'd6;

	// Register reset values.
	localparam logic [LIM_W-1:0] ACCUM_LIMIT_RST = 15'd80;
	localparam logic [LIM_W-1:0] ITERM_LIMIT_RST = 15'd300;
	localparam logic [LIM_W-1:0] DRIVE_LIMIT_RST = 15'd500;

	// Multiplier operand selection.
	localparam logic [1:0] MUL_DECAY = 2'd0;
	localparam logic [1:0] MUL_INT   = 2'd1;
	localparam logic [1:0] MUL_PROP  = 2'd2;
	localparam logic [1:0] MUL_DIFF  = 2'd3;

	// Accumulator operations.
	localparam logic [1:0] ACC_HOLD  = 2'd0;
	localparam logic [1:0] ACC_ITERM = 2'd1;
	localparam logic [1:0] ACC_ADD   = 2'd2;
	localparam logic [1:0] ACC_CLAMP = 2'd3;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] int_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]         accum_limit;
		logic [LIM_W-1:0]         iterm_limit;
		logic [LIM_W-1:0]         drive_limit;
		logic                     error_sign;
	} cfg_t;

	typedef struct packed {
		logic       load_in;
		logic [1:0] mul_sel;
		logic       upd_leak;
		logic [1:0] acc_op;
		logic       load_out;
	} cmd_t;

	function automatic logic signed [ACC_W-1:0] clamp_sym(
		input logic signed [ACC_W-1:0] x,
		input logic signed [ACC_W-1:0] lim
	);
		logic signed [ACC_W-1:0] r;
		if (x > lim) begin
			r = lim;
		end else if (x < -lim) begin
			r = -lim;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

// ----- src/leaky_pid_saturating.sv -----
// A PID controller with a leaky, clamped integral: each request of setpoint and
// measurement yields one drive value, the clamped PID sum truncated to an integer.
// A request is taken when the block is idle; it passes through the decay, leak,
// integral, proportional, derivative, sum and clamp steps, and its result is loaded
// into the output register once that is free; no request is taken before then.
// The single shared multiplier forms the decay product and the three gain products
// in turn. A finished result may wait in the output register while the next
// request is accepted and worked on. Configuration writes are always ready.
module leaky_pid_saturating (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [lps_pkg::SIG_W-1:0]   setpoint,
	input  logic signed [lps_pkg::SIG_W-1:0]   measurement,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lps_pkg::DRIVE_W-1:0] drive,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lps_pkg::IDX_W-1:0]          cfg_index,
	input  logic [lps_pkg::DATA_W-1:0]         cfg_data
);

	lps_pkg::cfg_t cfg;
	lps_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	lps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lps_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.setpoint    (setpoint),
		.measurement (measurement),
		.drive       (drive)
	);

endmodule

// ----- src/lps_cfg.sv -----
// Configuration registers of the leaky PID controller.
// Depends on lps_pkg for the register indexes, reset values and cfg_t.
module lps_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [lps_pkg::IDX_W-1:0]  wr_index,
	input  logic [lps_pkg::DATA_W-1:0] wr_data,
	output lps_pkg::cfg_t             cfg
);

	lps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.int_gain    <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.accum_limit <= lps_pkg::ACCUM_LIMIT_RST;
			cfg_q.iterm_limit <= lps_pkg::ITERM_LIMIT_RST;
			cfg_q.drive_limit <= lps_pkg::DRIVE_LIMIT_RST;
			cfg_q.error_sign  <= 1'b0;
		end else if (wr_en) begin
			// Writes to an index beyond the register list are dropped.
			case (wr_index)
				lps_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= $signed(wr_data[lps_pkg::GAIN_W-1:0]);
				end
				lps_pkg::REG_INT_GAIN: begin
					cfg_q.int_gain <= $signed(wr_data[lps_pkg::GAIN_W-1:0]);
				end
				lps_pkg::REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= $signed(wr_data[lps_pkg::GAIN_W-1:0]);
				end
				lps_pkg::REG_ACCUM_LIMIT: begin
					cfg_q.accum_limit <= wr_data[lps_pkg::LIM_W-1:0];
				end
				lps_pkg::REG_ITERM_LIMIT: begin
					cfg_q.iterm_limit <= wr_data[lps_pkg::LIM_W-1:0];
				end
				lps_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= wr_data[lps_pkg::LIM_W-1:0];
				end
				lps_pkg::REG_ERROR_SIGN: begin
					cfg_q.error_sign <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/lps_datapath.sv -----
// Datapath of the leaky PID controller: error, leaky integral, shared multiplier,
// term accumulator and output register. Depends on lps_pkg; steered by lps_ctrl.
module lps_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lps_pkg::cfg_t                     cfg,
	input  lps_pkg::cmd_t                     cmd,
	input  logic signed [lps_pkg::SIG_W-1:0]   setpoint,
	input  logic signed [lps_pkg::SIG_W-1:0]   measurement,
	output logic signed [lps_pkg::DRIVE_W-1:0] drive
);

	localparam int ACC_W  = lps_pkg::ACC_W;
	localparam int PROD_W = lps_pkg::PROD_W;
	localparam int SIG_W  = lps_pkg::SIG_W;
	localparam int ERR_W  = lps_pkg::ERR_W;
	localparam int DIFF_W = lps_pkg::DIFF_W;
	localparam int LIM_W  = lps_pkg::LIM_W;

	logic signed [ERR_W-1:0]             err_q;
	logic signed [ERR_W-1:0]             prev_err_q;
	logic signed [DIFF_W-1:0]            diff_q;
	logic signed [SIG_W-1:0]             leaky_q;
	logic signed [PROD_W-1:0]            prod_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic signed [lps_pkg::DRIVE_W-1:0]  drive_q;

	logic signed [ERR_W-1:0]             err_new;
	logic signed [DIFF_W-1:0]            mul_a;
	logic signed [lps_pkg::GAIN_W-1:0]   mul_b;
	logic signed [ACC_W-1:0]             prod_ext;
	logic signed [ACC_W-1:0]             err_ext;
	logic signed [ACC_W-1:0]             decayed;
	logic signed [ACC_W-1:0]             leak_sum;
	logic signed [ACC_W-1:0]             leak_clamped;
	logic signed [ACC_W-1:0]             accum_lim;
	logic signed [ACC_W-1:0]             iterm_lim;
	logic signed [ACC_W-1:0]             drive_lim;
	logic signed [ACC_W-1:0]             trunc_val;

	// Error, with the sign chosen by the mode register.
	always_comb begin
		if (cfg.error_sign) begin
			err_new = {setpoint[SIG_W-1], setpoint} - {measurement[SIG_W-1], measurement};
		end else begin
			err_new = {measurement[SIG_W-1], measurement} - {setpoint[SIG_W-1], setpoint};
		end
	end

	// Limits scaled to Q16.8 for the leaky sum and to Q.24 for the terms.
	assign accum_lim = $signed({{(ACC_W-LIM_W-lps_pkg::SIG_FRAC){1'b0}},
		cfg.accum_limit, {lps_pkg::SIG_FRAC{1'b0}}});
	assign iterm_lim = $signed({{(ACC_W-LIM_W-lps_pkg::PROD_FRAC){1'b0}},
		cfg.iterm_limit, {lps_pkg::PROD_FRAC{1'b0}}});
	assign drive_lim = $signed({{(ACC_W-LIM_W-lps_pkg::PROD_FRAC){1'b0}},
		cfg.drive_limit, {lps_pkg::PROD_FRAC{1'b0}}});

	assign prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
	assign err_ext  = $signed({{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q});

	// The decayed sum rounds to nearest with ties upward, then takes in the error.
	assign decayed      = (prod_ext + lps_pkg::DECAY_RND) >>> lps_pkg::DECAY_FRAC;
	assign leak_sum     = decayed + err_ext;
	assign leak_clamped = lps_pkg::clamp_sym(leak_sum, accum_lim);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			lps_pkg::MUL_DECAY: begin
				mul_a = {{(DIFF_W-SIG_W){leaky_q[SIG_W-1]}}, leaky_q};
				mul_b = lps_pkg::DECAY_Q16;
			end
			lps_pkg::MUL_INT: begin
				mul_a = {{(DIFF_W-SIG_W){leaky_q[SIG_W-1]}}, leaky_q};
				mul_b = cfg.int_gain;
			end
			lps_pkg::MUL_PROP: begin
				mul_a = {{(DIFF_W-ERR_W){err_q[ERR_W-1]}}, err_q};
				mul_b = cfg.prop_gain;
			end
			lps_pkg::MUL_DIFF: begin
				mul_a = diff_q;
				mul_b = cfg.deriv_gain;
			end
			default: begin
				mul_a = diff_q;
				mul_b = cfg.deriv_gain;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			err_q <= err_new;
		end
	end

	// Controller state that survives from one sample to the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaky_q    <= '0;
			prev_err_q <= '0;
		end else if (cmd.upd_leak) begin
			leaky_q    <= leak_clamped[SIG_W-1:0];
			prev_err_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_leak) begin
			diff_q <= {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			lps_pkg::ACC_ITERM: begin
				acc_q <= lps_pkg::clamp_sym(prod_ext, iterm_lim);
			end
			lps_pkg::ACC_ADD: begin
				acc_q <= acc_q + prod_ext;
			end
			lps_pkg::ACC_CLAMP: begin
				acc_q <= lps_pkg::clamp_sym(acc_q, drive_lim);
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Negative sums get a bias so that the shift truncates toward zero.
	assign trunc_val = acc_q[ACC_W-1] ? acc_q + lps_pkg::TRUNC_BIAS : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			drive_q <= trunc_val[lps_pkg::PROD_FRAC+lps_pkg::DRIVE_W-1:lps_pkg::PROD_FRAC];
		end
	end

	assign drive = drive_q;

endmodule

// ----- src/lps_ctrl.sv -----
// Sequencing controller of the leaky PID controller: steps one sample through
// the datapath and owns the channel handshakes. Depends on lps_pkg for cmd_t.
module lps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output lps_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DECAY = 4'd1;
	localparam logic [3:0] ST_LEAK  = 4'd2;
	localparam logic [3:0] ST_ITERM = 4'd3;
	localparam logic [3:0] ST_PTERM = 4'd4;
	localparam logic [3:0] ST_DTERM = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_CLAMP = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new result when empty or when its result leaves now.
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		cmd.mul_sel = lps_pkg::MUL_DECAY;
		cmd.acc_op  = lps_pkg::ACC_HOLD;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_next = ST_DECAY;
				end
			end
			ST_DECAY: begin
				cmd.mul_sel = lps_pkg::MUL_DECAY;
				state_next  = ST_LEAK;
			end
			ST_LEAK: begin
				cmd.upd_leak = 1'b1;
				state_next   = ST_ITERM;
			end
			ST_ITERM: begin
				cmd.mul_sel = lps_pkg::MUL_INT;
				state_next  = ST_PTERM;
			end
			ST_PTERM: begin
				cmd.acc_op  = lps_pkg::ACC_ITERM;
				cmd.mul_sel = lps_pkg::MUL_PROP;
				state_next  = ST_DTERM;
			end
			ST_DTERM: begin
				cmd.acc_op  = lps_pkg::ACC_ADD;
				cmd.mul_sel = lps_pkg::MUL_DIFF;
				state_next  = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_op = lps_pkg::ACC_ADD;
				state_next = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.acc_op = lps_pkg::ACC_CLAMP;
				state_next = ST_OUT;
			end
			ST_OUT: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- src/lps_checker.sv -----
// Port-level checks for the leaky PID controller, bound to the top level.
// Sees only the top-level ports; no package dependency.
module lps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] drive,
	input logic        cfg_ready
);

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive))
		else $error("result changed or vanished while stalled");

	// The clamped, truncated drive never reaches the most negative code.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != 16'h8000)
		else $error("drive outside the symmetric range");

	// An accepted request keeps the block busy for the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again right after a request");

	// A new result appears only as the block finishes a request.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind leaky_pid_saturating lps_checker u_lps_checker (.*);
